// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the servo PID RTL.
// No dependencies; include with the bare file name inside the module file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: property failed");

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/spp_pkg.sv =====
// Shared widths, register indexes, reset values and status types for the servo PID.
// No dependencies; imported by every other file of the block except assert_macros.svh.
package spp_pkg;

	localparam int POS_W      = 10;
	localparam int DT_W       = 16;
	localparam int ANGLE_W    = 8;
	localparam int GAIN_W     = 12;
	localparam int DUTY_W     = 8;
	localparam int ERR_W      = 12;
	localparam int DERR_W     = 13;
	localparam int INTEG_W    = 32;
	localparam int FRAC_W     = 8;

	localparam int MUL_A_W    = 32;
	localparam int MUL_B_W    = 12;
	localparam int MUL_CNT_W  = 4;
	localparam int PROD_W     = 44;
	localparam int M1_PROD_W  = DT_W + POS_W;
	localparam int QUO_W      = 34;
	localparam int DIVR_W     = 16;
	localparam int DIV_CNT_W  = 6;
	localparam int P_W        = 23;
	localparam int TERM_W     = 35;
	localparam int SUM_W      = 36;

	// target = floor(angle * 1023 / 260) = (angle * TARGET_MULT) >> TARGET_SHIFT
	localparam int TGT_PROD_W   = 26;
	localparam int TARGET_SHIFT = 16;
	localparam logic [17:0] TARGET_MULT = 18'd257859;

	localparam logic [DIVR_W-1:0] MS_PER_S = 16'd1000;

	localparam logic [INTEG_W-1:0] INTEG_MAX = 32'h7FFF_FFFF;
	localparam logic [INTEG_W-1:0] INTEG_MIN = 32'h8000_0000;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_STOP     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_STOP    = 3'd5;

	localparam logic [ANGLE_W-1:0] RST_TARGET_ANGLE = 8'd0;
	localparam logic [GAIN_W-1:0]  RST_PROP_GAIN    = 12'd256;
	localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN   = 12'd26;
	localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN   = 12'd77;
	localparam logic [POS_W-1:0]   RST_LOW_STOP     = 10'd190;
	localparam logic [POS_W-1:0]   RST_HIGH_STOP    = 10'd940;

	typedef struct packed {
		logic busy;
		logic done;
	} arith_stat_t;

endpackage

// ===== rtl/spp_if.sv =====
// Valid/ready channel interfaces for the servo PID sample and duty beats.
// Depends on spp_pkg for the field widths.
interface spp_in_if import spp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [POS_W-1:0]   position_sample;
	logic [DT_W-1:0]    elapsed_ms;

	modport source (output valid, output position_sample, output elapsed_ms, input ready);
	modport sink (input valid, input position_sample, input elapsed_ms, output ready);
endinterface

interface spp_out_if import spp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DUTY_W-1:0]  forward_duty;
	logic [DUTY_W-1:0]  reverse_duty;

	modport source (output valid, output forward_duty, output reverse_duty, input ready);
	modport sink (input valid, input forward_duty, input reverse_duty, output ready);
endinterface

// ===== rtl/spp_mul.sv =====
// Serial shift-add multiplier: one bit of the short operand per cycle.
// Depends on spp_pkg; product holds until the next start.
module spp_mul import spp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MUL_A_W-1:0]  a,
	input  logic [MUL_B_W-1:0]  b,
	output arith_stat_t         stat,
	output logic [PROD_W-1:0]   product
);

	logic                 busy_q;
	logic                 done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [PROD_W-1:0]    a_q;
	logic [MUL_B_W-1:0]   b_q;
	logic [PROD_W-1:0]    acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(MUL_B_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= PROD_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = acc_q;

endmodule

// ===== rtl/spp_div.sv =====
// Serial restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on spp_pkg; the dividend bits above the quotient must be below the divisor.
module spp_div import spp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [PROD_W-1:0]   dividend,
	input  logic [DIVR_W-1:0]   divisor,
	output arith_stat_t         stat,
	output logic [QUO_W-1:0]    quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVR_W-1:0]    rem_q;
	logic [QUO_W-1:0]     num_q;
	logic [DIVR_W-1:0]    divisor_q;

	logic [DIVR_W:0]      shifted;
	logic [DIVR_W+1:0]    diff;
	logic                 fits;
	logic [DIVR_W-1:0]    rem_next;

	always_comb begin
		shifted  = {rem_q, num_q[QUO_W-1]};
		diff     = {1'b0, shifted} - {2'b00, divisor_q};
		fits     = !diff[DIVR_W+1];
		rem_next = fits ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// quotient bits shift in at the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= DIVR_W'(dividend[PROD_W-1:QUO_W]);
			num_q     <= dividend[QUO_W-1:0];
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			num_q <= {num_q[QUO_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = num_q;

endmodule

// ===== rtl/servo_position_pid.sv =====
// Servo position PID: one sample in flight; the next sample is taken once the previous one
// reaches the duty register. Each sample runs four 12-step serial multiplies and two 34-step
// serial divides, one divide when elapsed_ms is zero. A finished duty beat waits in its own
// register while the next sample is computed; the next result holds in ST_OUT until it is taken.
// arst_n clears the integral and the previous error and loads the register defaults.
// Depends on spp_pkg, spp_if, spp_mul, spp_div and assert_macros.svh.
`include "assert_macros.svh"

module servo_position_pid import spp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	spp_in_if.sink                sample,
	spp_out_if.source             duty,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_TGT  = 4'd1;
	localparam logic [3:0] ST_ERR  = 4'd2;
	localparam logic [3:0] ST_M1   = 4'd3;
	localparam logic [3:0] ST_M2   = 4'd4;
	localparam logic [3:0] ST_M3   = 4'd5;
	localparam logic [3:0] ST_DI   = 4'd6;
	localparam logic [3:0] ST_M4   = 4'd7;
	localparam logic [3:0] ST_DD   = 4'd8;
	localparam logic [3:0] ST_SUM  = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;

	logic [3:0]          state_q;

	logic [ANGLE_W-1:0]  target_angle_q;
	logic [GAIN_W-1:0]   prop_gain_q;
	logic [GAIN_W-1:0]   integ_gain_q;
	logic [GAIN_W-1:0]   deriv_gain_q;
	logic [POS_W-1:0]    low_stop_q;
	logic [POS_W-1:0]    high_stop_q;

	logic [INTEG_W-1:0]  integral_q;
	logic [ERR_W-1:0]    prev_q;

	logic [POS_W-1:0]    pos_q;
	logic [DT_W-1:0]     dt_q;
	logic [ERR_W-1:0]    err_q;
	logic [P_W-1:0]      p_q;
	logic [TERM_W-1:0]   i_q;
	logic [TERM_W-1:0]   d_q;
	logic [SUM_W-1:0]    sum_q;
	logic                out_valid_q;
	logic [DUTY_W-1:0]   fwd_q;
	logic [DUTY_W-1:0]   rev_q;

	logic                accept;
	logic                out_load;

	logic [TGT_PROD_W-1:0] tgt_prod;
	logic [POS_W-1:0]      target;
	logic [ERR_W-1:0]      err_mag;
	logic [DERR_W-1:0]     derr;
	logic [DERR_W-1:0]     derr_mag;
	logic [INTEG_W-1:0]    integ_mag;
	logic [INTEG_W+1:0]    integ_step;
	logic [INTEG_W+1:0]    integ_sum;
	logic [INTEG_W-1:0]    integ_next;
	logic [PROD_W-1:0]     d_num;

	logic                  mul_start;
	logic [MUL_A_W-1:0]    mul_a;
	logic [MUL_B_W-1:0]    mul_b;
	arith_stat_t           mul_st;
	logic [PROD_W-1:0]     mul_prod;

	logic                  div_start;
	logic [PROD_W-1:0]     div_dividend;
	logic [DIVR_W-1:0]     div_divisor;
	arith_stat_t           div_st;
	logic [QUO_W-1:0]      div_quo;

	logic                  sum_neg;
	logic [SUM_W-1:0]      sum_mag;
	logic [SUM_W-FRAC_W-1:0] drv_whole;
	logic [DUTY_W-1:0]     drv_mag;
	logic                  stop_hit;
	logic [DUTY_W-1:0]     drv_final;

	assign accept       = sample.valid && sample.ready;
	assign sample.ready = (state_q == ST_IDLE);
	assign out_load     = (state_q == ST_OUT) && (!out_valid_q || duty.ready);

	assign duty.valid        = out_valid_q;
	assign duty.forward_duty = fwd_q;
	assign duty.reverse_duty = rev_q;

	// error terms and integral update
	always_comb begin
		tgt_prod  = TGT_PROD_W'(target_angle_q) * TGT_PROD_W'(TARGET_MULT);
		target    = tgt_prod[TARGET_SHIFT +: POS_W];
		err_mag   = err_q[ERR_W-1] ? (~err_q + 1'b1) : err_q;
		derr      = {err_q[ERR_W-1], err_q} - {prev_q[ERR_W-1], prev_q};
		derr_mag  = derr[DERR_W-1] ? (~derr + 1'b1) : derr;
		integ_mag = integral_q[INTEG_W-1] ? (~integral_q + 1'b1) : integral_q;

		integ_step = (INTEG_W+2)'(mul_prod[M1_PROD_W-1:0]);
		if (err_q[ERR_W-1]) begin
			integ_step = ~integ_step + 1'b1;
		end
		integ_sum = {{2{integral_q[INTEG_W-1]}}, integral_q} + integ_step;
		if ((integ_sum[INTEG_W+1] != integ_sum[INTEG_W-1]) ||
				(integ_sum[INTEG_W] != integ_sum[INTEG_W-1])) begin
			integ_next = integ_sum[INTEG_W+1] ? INTEG_MIN : INTEG_MAX;
		end else begin
			integ_next = integ_sum[INTEG_W-1:0];
		end

		// x * 1000 = x * 1024 - x * 16 - x * 8
		d_num = (PROD_W'(mul_prod[P_W-1:0]) << 10) - (PROD_W'(mul_prod[P_W-1:0]) << 4)
			- (PROD_W'(mul_prod[P_W-1:0]) << 3);
	end

	// launch the shared units as each step completes
	always_comb begin
		mul_start    = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		unique case (state_q)
			ST_ERR: begin
				mul_start = 1'b1;
				mul_a     = MUL_A_W'(dt_q);
				mul_b     = MUL_B_W'(err_mag);
			end
			ST_M1: begin
				mul_start = mul_st.done;
				mul_a     = MUL_A_W'(err_mag);
				mul_b     = prop_gain_q;
			end
			ST_M2: begin
				mul_start = mul_st.done;
				mul_a     = integ_mag;
				mul_b     = integ_gain_q;
			end
			ST_M3: begin
				div_start    = mul_st.done;
				div_dividend = mul_prod;
				div_divisor  = MS_PER_S;
			end
			ST_DI: begin
				mul_start = div_st.done;
				mul_a     = MUL_A_W'(derr_mag);
				mul_b     = deriv_gain_q;
			end
			ST_M4: begin
				div_start    = mul_st.done && (dt_q != '0);
				div_dividend = d_num;
				div_divisor  = dt_q;
			end
			default: begin
			end
		endcase
	end

	// truncate toward zero, clamp, then apply the end stops
	always_comb begin
		sum_neg   = sum_q[SUM_W-1];
		sum_mag   = sum_neg ? (~sum_q + 1'b1) : sum_q;
		drv_whole = sum_mag[SUM_W-1:FRAC_W];
		drv_mag   = (|drv_whole[SUM_W-FRAC_W-1:DUTY_W]) ? '1 : drv_whole[DUTY_W-1:0];
		stop_hit  = (drv_mag != '0) &&
			((sum_neg && (pos_q < low_stop_q)) || (!sum_neg && (pos_q > high_stop_q)));
		drv_final = stop_hit ? '0 : drv_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_angle_q <= RST_TARGET_ANGLE;
			prop_gain_q    <= RST_PROP_GAIN;
			integ_gain_q   <= RST_INTEG_GAIN;
			deriv_gain_q   <= RST_DERIV_GAIN;
			low_stop_q     <= RST_LOW_STOP;
			high_stop_q    <= RST_HIGH_STOP;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TARGET_ANGLE: target_angle_q <= wr_data[ANGLE_W-1:0];
				REG_PROP_GAIN:    prop_gain_q    <= wr_data[GAIN_W-1:0];
				REG_INTEG_GAIN:   integ_gain_q   <= wr_data[GAIN_W-1:0];
				REG_DERIV_GAIN:   deriv_gain_q   <= wr_data[GAIN_W-1:0];
				REG_LOW_STOP:     low_stop_q     <= wr_data[POS_W-1:0];
				REG_HIGH_STOP:    high_stop_q    <= wr_data[POS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			integral_q  <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (duty.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_TGT;
				ST_TGT:  state_q <= ST_ERR;
				ST_ERR:  state_q <= ST_M1;
				ST_M1: begin
					if (mul_st.done) begin
						integral_q <= integ_next;
						state_q    <= ST_M2;
					end
				end
				ST_M2:   if (mul_st.done) state_q <= ST_M3;
				ST_M3:   if (mul_st.done) state_q <= ST_DI;
				ST_DI:   if (div_st.done) state_q <= ST_M4;
				ST_M4: begin
					if (mul_st.done) begin
						state_q <= (dt_q == '0) ? ST_SUM : ST_DD;
					end
				end
				ST_DD:   if (div_st.done) state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						prev_q  <= err_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					pos_q <= {sample.position_sample[POS_W-1:2], 2'b00};
					dt_q  <= sample.elapsed_ms;
				end
			end
			ST_TGT: err_q <= ERR_W'(target) - ERR_W'(pos_q);
			ST_M2: begin
				if (mul_st.done) begin
					p_q <= err_q[ERR_W-1] ? (~{1'b0, mul_prod[P_W-2:0]} + 1'b1)
						: {1'b0, mul_prod[P_W-2:0]};
				end
			end
			ST_DI: begin
				if (div_st.done) begin
					i_q <= integral_q[INTEG_W-1] ? (~{1'b0, div_quo} + 1'b1) : {1'b0, div_quo};
				end
			end
			ST_M4: if (mul_st.done && (dt_q == '0)) d_q <= '0;
			ST_DD: begin
				if (div_st.done) begin
					d_q <= derr[DERR_W-1] ? (~{1'b0, div_quo} + 1'b1) : {1'b0, div_quo};
				end
			end
			ST_SUM: begin
				sum_q <= {{(SUM_W-P_W){p_q[P_W-1]}}, p_q}
					+ {{(SUM_W-TERM_W){i_q[TERM_W-1]}}, i_q}
					+ {{(SUM_W-TERM_W){d_q[TERM_W-1]}}, d_q};
			end
			ST_OUT: begin
				if (out_load) begin
					fwd_q <= sum_neg ? '0 : drv_final;
					rev_q <= sum_neg ? drv_final : '0;
				end
			end
			default: begin
			end
		endcase
	end

	spp_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.stat    (mul_st),
		.product (mul_prod)
	);

	spp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_st),
		.quotient (div_quo)
	);

	`ASSERT_IMPLIES(a_mul_free, clk, arst_n, mul_start, !mul_st.busy)
	`ASSERT_IMPLIES(a_div_free, clk, arst_n, div_start, !div_st.busy)
	`ASSERT_IMPLIES(a_div_range, clk, arst_n, div_start, DIVR_W'(div_dividend[PROD_W-1:QUO_W]) < div_divisor)
	`ASSERT_IMPLIES(a_idle_units, clk, arst_n, state_q == ST_IDLE, !mul_st.busy && !div_st.busy)
	`ASSERT_IMPLIES(a_duty_excl, clk, arst_n, out_valid_q, (fwd_q == '0) || (rev_q == '0))

endmodule
